### hdl/chacha20_stream_xor_assert.svh
`ifndef CHACHA20_STREAM_XOR_ASSERT_SVH
`define CHACHA20_STREAM_XOR_ASSERT_SVH
// Check that a condition holds at every clock edge outside reset.
`define CC_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");
// Check that a trigger is followed by a consequence in the next cycle.
`define CC_ASSERT_NEXT(label, clk, rstn, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) \
        else $error("assertion failed");
`endif

### hdl/cc20_pkg.sv
package cc20_pkg;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_RUN
    } core_state_t;

    typedef enum logic [2:0] {
        REG_KEY0,
        REG_KEY1,
        REG_KEY2,
        REG_KEY3,
        REG_NONCE_LO,
        REG_NONCE_HI
    } reg_index_t;

    localparam word_t SIGMA0 = 32'h61707865;
    localparam word_t SIGMA1 = 32'h3320646e;
    localparam word_t SIGMA2 = 32'h79622d32;
    localparam word_t SIGMA3 = 32'h6b206574;

    // Quarter-round lanes for column rounds and diagonal rounds.
    localparam logic [3:0] COL_IDX [4][4] = '{
        '{4'd0, 4'd4, 4'd8,  4'd12},
        '{4'd1, 4'd5, 4'd9,  4'd13},
        '{4'd2, 4'd6, 4'd10, 4'd14},
        '{4'd3, 4'd7, 4'd11, 4'd15}
    };
    localparam logic [3:0] DIAG_IDX [4][4] = '{
        '{4'd0, 4'd5, 4'd10, 4'd15},
        '{4'd1, 4'd6, 4'd11, 4'd12},
        '{4'd2, 4'd7, 4'd8,  4'd13},
        '{4'd3, 4'd4, 4'd9,  4'd14}
    };

    // One half of a quarter round: first half rotates by 16 and 12,
    // second half by 8 and 7.
    function automatic quad_t qhalf(input quad_t q, input logic second);
        quad_t r;
        word_t t;
        r = q;
        r.a = q.a + q.b;
        t = q.d ^ r.a;
        r.d = second ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
        r.c = q.c + r.d;
        t = q.b ^ r.c;
        r.b = second ? {t[24:0], t[31:25]} : {t[19:0], t[31:20]};
        return r;
    endfunction

endpackage

### hdl/chacha20_stream_xor.sv
// ChaCha20 byte-stream XOR.
// Input channel (s_valid/s_ready): one request carries s_data_byte and
// s_end_of_message. Result channel (m_valid/m_ready): one request per input
// carries m_out_byte = data XOR keystream and m_out_last = end mark.
// Configuration channel (cfg_valid/cfg_ready, always ready): cfg_index picks
// key words 0..3, nonce low, nonce high; other indexes are dropped.
// Write configuration only between messages, with the block idle.
// Inputs enter a 4-deep queue; the back end computes a 64-byte keystream
// block at byte position 0, one half round per cycle on four parallel
// quarter-round lanes, then adds the initial state and XORs one byte per
// cycle, up to 64 bytes, while a byte is queued and the result register is
// free. Within a block a byte passes through the queue and result register.
// The end mark resets the block counter and byte position to 0.
// Reset (aresetn low, synchronous) clears the queue, counter, position,
// key and nonce. When the receiver stalls, the result register holds, the
// queue fills, and s_ready drops after four queued requests.
module chacha20_stream_xor import cc20_pkg::*; #(
    parameter int ROUNDS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_out_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic        q_valid;
    item_t       q_item;
    logic        q_pop;

    // Always take configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            key3_reg     <= '0;
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KEY0:     key0_reg     <= cfg_data;
                REG_KEY1:     key1_reg     <= cfg_data;
                REG_KEY2:     key2_reg     <= cfg_data;
                REG_KEY3:     key3_reg     <= cfg_data;
                REG_NONCE_LO: nonce_lo_reg <= cfg_data;
                REG_NONCE_HI: nonce_hi_reg <= cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: queue incoming requests.
    cc20_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_message (s_end_of_message),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop)
    );

    // Back end: generate keystream blocks and XOR bytes.
    cc20_core #(.ROUNDS(ROUNDS)) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .key        ({key3_reg, key2_reg, key1_reg, key0_reg}),
        .nonce      ({nonce_hi_reg, nonce_lo_reg}),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

endmodule

### hdl/cc20_front.sv
module cc20_front import cc20_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_message,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_pop
);

    localparam int DEPTH = 4;

    item_t      mem [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign s_ready = (count_reg != 3'(DEPTH));
    assign q_valid = (count_reg != 3'd0);
    assign q_item  = mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + 3'(push) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= '{data: s_data_byte, last: s_end_of_message};
        end
    end

endmodule

### hdl/cc20_core.sv
module cc20_core import cc20_pkg::*; #(
    parameter int ROUNDS = 20
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [255:0] key,
    input  logic [95:0]  nonce,
    input  logic         q_valid,
    input  item_t        q_item,
    output logic         q_pop,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_out_byte,
    output logic         m_out_last
);

    localparam int STEPS  = 2 * ROUNDS;
    localparam int STEP_W = $clog2(STEPS);

    core_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [31:0]       counter_reg, counter_next;
    logic [5:0]        pos_reg, pos_next;
    word_t             work_reg [16];
    word_t             work_next [16];
    word_t             init_reg [16];
    word_t             init_next [16];
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_byte_reg;
    logic              m_last_reg;
    logic              out_free;
    logic              diag;
    logic              second;
    word_t             ks_word;
    logic [7:0]        ks_byte;

    assign out_free   = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_last = m_last_reg;
    assign diag       = step_reg[1];
    assign second     = step_reg[0];
    assign ks_word    = work_reg[pos_reg[5:2]];
    assign ks_byte    = ks_word[{pos_reg[1:0], 3'b000} +: 8];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (q_valid) state_next = ST_ROUND;
            ST_ROUND: if (step_reg == STEP_W'(STEPS - 1)) state_next = ST_ADD;
            ST_ADD:   state_next = ST_RUN;
            ST_RUN:   if (q_pop && (q_item.last || pos_reg == 6'd63)) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        quad_t      qin;
        quad_t      qout;
        logic [3:0] ix [4];
        qin          = '0;
        qout         = '0;
        ix           = '{4'd0, 4'd0, 4'd0, 4'd0};
        q_pop        = 1'b0;
        step_next    = step_reg;
        counter_next = counter_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg && !m_ready;
        init_next    = init_reg;
        work_next    = work_reg;
        case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (q_valid) begin
                    init_next[0]  = SIGMA0;
                    init_next[1]  = SIGMA1;
                    init_next[2]  = SIGMA2;
                    init_next[3]  = SIGMA3;
                    for (int i = 0; i < 8; i++) begin
                        init_next[4 + i] = key[32*i +: 32];
                    end
                    init_next[12] = counter_reg;
                    init_next[13] = nonce[31:0];
                    init_next[14] = nonce[63:32];
                    init_next[15] = nonce[95:64];
                    work_next     = init_next;
                    counter_next  = counter_reg + 32'd1;
                end
            end
            ST_ROUND: begin
                step_next = step_reg + STEP_W'(1);
                for (int q = 0; q < 4; q++) begin
                    for (int k = 0; k < 4; k++) begin
                        ix[k] = diag ? DIAG_IDX[q][k] : COL_IDX[q][k];
                    end
                    qin  = '{a: work_reg[ix[0]], b: work_reg[ix[1]],
                             c: work_reg[ix[2]], d: work_reg[ix[3]]};
                    qout = qhalf(qin, second);
                    work_next[ix[0]] = qout.a;
                    work_next[ix[1]] = qout.b;
                    work_next[ix[2]] = qout.c;
                    work_next[ix[3]] = qout.d;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 16; i++) begin
                    work_next[i] = work_reg[i] + init_reg[i];
                end
            end
            ST_RUN: begin
                if (q_valid && out_free) begin
                    q_pop        = 1'b1;
                    m_valid_next = 1'b1;
                    if (q_item.last) begin
                        counter_next = '0;
                        pos_next     = '0;
                    end else begin
                        pos_next = pos_reg + 6'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            counter_reg <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            counter_reg <= counter_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        init_reg <= init_next;
        if (q_pop) begin
            m_byte_reg <= q_item.data ^ ks_byte;
            m_last_reg <= q_item.last;
        end
    end

endmodule

### hdl/cc20_check.sv
`include "chacha20_stream_xor_assert.svh"
module cc20_check (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_out_last,
    input logic       cfg_ready
);

    `CC_ASSERT_ALWAYS(a_cfg_ready, aclk, 1'b1, cfg_ready)
    `CC_ASSERT_NEXT(a_reset_clears, aclk, 1'b1, !aresetn, !m_valid && s_ready)
    `CC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_out_byte) && $stable(m_out_last))

endmodule

bind chacha20_stream_xor cc20_check u_cc20_check (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_out_last (m_out_last),
    .cfg_ready  (cfg_ready)
);
